// ===== sv/lru_kv_pkg.sv =====
package lru_kv_pkg;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Fixed field widths of the request and response
    localparam int unsigned KEY_PORT_W = 32;
    localparam int unsigned VAL_PORT_W = 64;
    localparam int unsigned LEN_W      = 4;

    typedef struct packed {
        logic                  operation;
        logic [KEY_PORT_W-1:0] key;
        logic [VAL_PORT_W-1:0] value;
        logic [LEN_W-1:0]      set_length;
    } lru_kv_req_t;

    typedef struct packed {
        logic                  hit;
        logic [VAL_PORT_W-1:0] read_value;
        logic [LEN_W-1:0]      read_length;
    } lru_kv_rsp_t;

    // Control that runs along the cell chain
    typedef struct packed {
        logic update;   // the chain moves this cycle
        logic cut;      // an earlier cell already stopped the shift
    } lru_kv_link_t;

endpackage

// ===== sv/lru_kv_cell.sv =====
module lru_kv_cell
    import lru_kv_pkg::*;
#(
    parameter int unsigned KEY_W = 32,
    parameter int unsigned VAL_W = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [KEY_W-1:0]          cmp_key,
    input  lru_kv_link_t              link_in,
    input  logic                      prev_valid,
    input  logic [KEY_W-1:0]          prev_key,
    input  logic [VAL_W-1:0]          prev_value,
    input  logic [LEN_W-1:0]          prev_length,
    output lru_kv_link_t              link_out,
    output logic                      valid,
    output logic [KEY_W-1:0]          key,
    output logic [VAL_W-1:0]          value,
    output logic [LEN_W-1:0]          length,
    output logic                      match
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [LEN_W-1:0] length_reg;
    logic             shift;
    logic             stop;

    // Key compare against the pending request
    assign match = valid_reg && (key_reg == cmp_key);

    // The shift stops at the matching entry or at the first empty cell
    assign stop  = match || !valid_reg;
    assign shift = link_in.update && !link_in.cut;

    assign link_out.update = link_in.update;
    assign link_out.cut    = link_in.cut || stop;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    // Entry payload, taken from the neighbor on a shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg    <= prev_key;
            value_reg  <= prev_value;
            length_reg <= prev_length;
        end
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign value  = value_reg;
    assign length = length_reg;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Request channel: a transfer happens at a rising edge with start high and
// busy low; request carries a get or a set with key, value and length.
// Response channel: done is high for exactly one cycle and response holds
// hit, read_value and read_length for that cycle; the receiver takes it
// then and cannot hold it off.
// Entries sit in a chain of cells ordered by recency: cell 0 is the most
// recent entry and the last valid cell the least recent. A hit or an
// insert moves the entry to cell 0 while every cell in front of it moves
// one place back; an insert into a full chain drops the last cell.
// Order: the request transfer sets busy_reg, and the end of the compare
// cycle sets done_reg, which drives done beside the registered response.
// Flow: busy is high for the one compare and shift cycle, in which all
// cells compare keys in parallel and the stop of the shift ripples along
// the chain; a new request can transfer while done shows the last response.
// Reset clears every valid flag, so the cache starts empty; stored keys and
// values are not cleared. No request is held back after reset.
module lru_key_value_cache
    import lru_kv_pkg::*;
#(
    parameter int unsigned CAPACITY    = 8,
    parameter int unsigned KEY_BITS    = 32,
    parameter int unsigned VALUE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  lru_kv_req_t request,
    output logic        done,
    output lru_kv_rsp_t response
);

    localparam int unsigned KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int unsigned VAL_W = VALUE_BYTES * 8;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    lru_kv_rsp_t           result_reg;
    lru_kv_rsp_t           result_next;

    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [LEN_W-1:0]      length_reg;

    logic [LEN_W-1:0]      len_sat;
    logic [VAL_W-1:0]      val_masked;
    logic                  accept;

    logic [CAPACITY-1:0]             cell_valid;
    logic [CAPACITY-1:0][KEY_W-1:0]  cell_key;
    logic [CAPACITY-1:0][VAL_W-1:0]  cell_value;
    logic [CAPACITY-1:0][LEN_W-1:0]  cell_length;
    logic [CAPACITY-1:0]             cell_match;
    lru_kv_link_t [CAPACITY:0]       link;

    logic                  hit;
    logic [VAL_W-1:0]      hit_value;
    logic [LEN_W-1:0]      hit_length;
    logic [VAL_W-1:0]      front_value;
    logic [LEN_W-1:0]      front_length;

    assign accept = start && !busy_reg;

    // Length saturation and byte masking of the incoming value
    always_comb
    begin
        if (request.set_length > LEN_W'(VALUE_BYTES))
        begin
            len_sat = LEN_W'(VALUE_BYTES);
        end
        else
        begin
            len_sat = request.set_length;
        end
        for (int b = 0; b < VALUE_BYTES; b++)
        begin
            if (LEN_W'(b) < len_sat)
            begin
                val_masked[b*8 +: 8] = request.value[b*8 +: 8];
            end
            else
            begin
                val_masked[b*8 +: 8] = 8'h00;
            end
        end
    end

    // Request register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= request.operation;
            key_reg    <= request.key[KEY_W-1:0];
            value_reg  <= val_masked;
            length_reg <= len_sat;
        end
    end

    // Hit detect and read-out of the matching cell
    always_comb
    begin
        hit        = |cell_match;
        hit_value  = '0;
        hit_length = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_match[i])
            begin
                hit_value  = hit_value | cell_value[i];
                hit_length = hit_length | cell_length[i];
            end
        end
    end

    // Entry that enters cell 0
    assign front_value  = (op_reg == OP_SET) ? value_reg  : hit_value;
    assign front_length = (op_reg == OP_SET) ? length_reg : hit_length;

    // The chain moves on a set or on a get that hits
    assign link[0].update = busy_reg && ((op_reg == OP_SET) || hit);
    assign link[0].cut    = 1'b0;

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lru_kv_cell #(
                .KEY_W (KEY_W),
                .VAL_W (VAL_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmp_key     (key_reg),
                .link_in     (link[i]),
                .prev_valid  (1'b1),
                .prev_key    (key_reg),
                .prev_value  (front_value),
                .prev_length (front_length),
                .link_out    (link[i+1]),
                .valid       (cell_valid[i]),
                .key         (cell_key[i]),
                .value       (cell_value[i]),
                .length      (cell_length[i]),
                .match       (cell_match[i])
            );
        end
        else
        begin : g_body
            lru_kv_cell #(
                .KEY_W (KEY_W),
                .VAL_W (VAL_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmp_key     (key_reg),
                .link_in     (link[i]),
                .prev_valid  (cell_valid[i-1]),
                .prev_key    (cell_key[i-1]),
                .prev_value  (cell_value[i-1]),
                .prev_length (cell_length[i-1]),
                .link_out    (link[i+1]),
                .valid       (cell_valid[i]),
                .key         (cell_key[i]),
                .value       (cell_value[i]),
                .length      (cell_length[i]),
                .match       (cell_match[i])
            );
        end
    end

    // Control and response next state
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (busy_reg)
        begin
            busy_next               = 1'b0;
            done_next               = 1'b1;
            result_next.hit         = hit;
            result_next.read_value  = '0;
            result_next.read_length = '0;
            if ((op_reg == OP_GET) && hit)
            begin
                result_next.read_value  = VAL_PORT_W'(hit_value);
                result_next.read_length = hit_length;
            end
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign response = result_reg;

    // Checks
    a_one_cycle_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg && done_reg)
        else $error("compare cycle did not end in a response");

    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("request transfer did not start work");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(cell_match))
        else $error("key matches more than one cell");

    a_packed_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
        else $error("valid cells are not packed at the head of the chain");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("response shown while busy");

endmodule
